### design/ofg_pkg.sv
// ----------------------------------------------------------------------------
// ofg_pkg: shared types and constants of the optical flow gradient unit
// Payload structs, the job record passed from front to back, fixed codes.
// ----------------------------------------------------------------------------
package ofg_pkg;

	localparam int MAX_HEIGHT = 1024;

	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [10:0] HEIGHT_RESET = 11'd480;
	localparam logic [10:0] SIZE_MIN     = 11'd3;

	// border positions carry this code instead of a gradient
	localparam logic [7:0]  FILL_CODE   = 8'd5;
	// temporal offset 5*256
	localparam logic [11:0] TEMP_OFFSET = 12'd1280;
	// n/10 == (n*6554)>>16 for n < 16384
	localparam logic [12:0] DIV10_MUL   = 13'd6554;

	localparam int JOB_DEPTH = 8;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_LVL_W = $clog2(JOB_DEPTH + 1);

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// result slots of one job, in emission order
	typedef enum logic [3:0] {
		SLOT_A = 4'b0001,	// (row-1, col-1)
		SLOT_B = 4'b0010,	// (row-1, col), last column
		SLOT_C = 4'b0100,	// (row, col-1), last row
		SLOT_D = 4'b1000	// (row, col), last row and column
	} slot_t;

	typedef struct packed {
		logic [7:0] prev_pixel;
		logic [7:0] curr_pixel;
	} pixel_pair_t;

	typedef struct packed {
		logic [9:0] out_row;
		logic [9:0] out_col;
		logic [7:0] grad_x;
		logic [7:0] grad_y;
		logic [7:0] grad_t;
		logic       last_of_run;
	} result_t;

	// everything the back end needs to emit the results of one input
	typedef struct packed {
		logic [9:0] row;
		logic [9:0] col;
		logic [3:0] slots;
		logic [7:0] a_gx;
		logic [7:0] a_gy;
		logic [7:0] a_gt;
		logic [7:0] b_gx;
		logic [7:0] c_gy;
	} job_t;

endpackage

### design/ofg_front.sv
// ----------------------------------------------------------------------------
// ofg_front: pixel intake, line store, window and gradient arithmetic
// Tracks the raster position, keeps two rows per frame, builds one job per
// input holding the finished gradient codes of every result it causes.
// ----------------------------------------------------------------------------
module ofg_front import ofg_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  pixel_pair_t          pixels,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [10:0]          cfg_data,
	input  logic [JOB_LVL_W-1:0] level,
	output logic                 job_push,
	output job_t                 job
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WE_W  = $clog2(MAX_WIDTH + 1);

	typedef struct packed {
		logic [9:0] row;
		logic [9:0] col;
		logic       em_a;
		logic       em_b;
		logic       last_row;
		logic       k_ge2;
		logic       r_ge2;
	} pos_t;

	typedef struct packed {
		logic [7:0] prev_up2;
		logic [7:0] prev_up1;
		logic [7:0] curr_up2;
		logic [7:0] curr_up1;
	} line_word_t;

	logic [10:0]      width_q, height_q;
	logic [WE_W-1:0]  w_eff;
	logic [10:0]      h_eff;
	logic [COL_W-1:0] col_q, k, k_s1;
	logic [9:0]       row_q, rr;
	logic             k_last, r_last, acc;
	logic [4:0]       occupancy;

	logic             s1_v_q, s2_v_q;
	pos_t             pos_now, pos_s1, pos_s2;
	pixel_pair_t      pix_s1;
	line_word_t       rd_s1;
	line_word_t       line_mem [MAX_WIDTH];

	logic [7:0]       win_q [2][3][3];
	logic [7:0]       up2 [2], up1 [2], nw [2];

	logic [7:0]       gx_a, gx_b, gy_a, gy_c, gt_a;
	logic [10:0]      x_prev, x_curr;
	logic [11:0]      t_num;
	logic [24:0]      t_prod;

	function automatic logic [9:0] sum4(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		return 10'(a) + 10'(b) + 10'(c) + 10'(d);
	endfunction

	function automatic logic [10:0] sum5(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d, input logic [7:0] e);
		return 11'(a) + 11'(b) + 11'(c) + 11'(d) + 11'(e);
	endfunction

	// ((pos-neg)/4 + 256)/2, both divisions truncating toward zero
	function automatic logic [7:0] grad_code(input logic [9:0] pos, input logic [9:0] neg);
		logic signed [11:0] s, q, v, g;
		s = $signed({2'b00, pos}) - $signed({2'b00, neg});
		q = (s < 0) ? -((-s) >>> 2) : (s >>> 2);
		v = q + 12'sd256;
		g = (v < 0) ? -((-v) >>> 1) : (v >>> 1);
		return g[7:0];
	endfunction

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- position ----
	always_comb begin
		if (width_q < SIZE_MIN)
			w_eff = WE_W'(SIZE_MIN);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			w_eff = WE_W'(MAX_WIDTH);
		else
			w_eff = WE_W'(width_q);

		if (height_q < SIZE_MIN)
			h_eff = SIZE_MIN;
		else if (height_q > 11'(MAX_HEIGHT))
			h_eff = 11'(MAX_HEIGHT);
		else
			h_eff = height_q;

		k      = (WE_W'(col_q) < w_eff) ? col_q : COL_W'(w_eff - WE_W'(1));
		rr     = ({1'b0, row_q} < h_eff) ? row_q : 10'(h_eff - 11'd1);
		k_last = (WE_W'(k) == w_eff - WE_W'(1));
		r_last = ({1'b0, rr} == h_eff - 11'd1);

		pos_now.row      = rr;
		pos_now.col      = 10'(k);
		pos_now.em_a     = (rr != 10'd0) && (k != '0);
		pos_now.em_b     = (rr != 10'd0) && k_last;
		pos_now.last_row = r_last;
		pos_now.k_ge2    = (k > COL_W'(1));
		pos_now.r_ge2    = (rr > 10'd1);
	end

	// jobs in flight plus queued never exceed the queue depth
	assign occupancy = 5'(level) + 5'(s1_v_q) + 5'(s2_v_q);
	assign full      = (occupancy >= 5'(JOB_DEPTH));
	assign acc       = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			s1_v_q <= acc;
			s2_v_q <= s1_v_q;
			if (acc) begin
				if (k_last) begin
					col_q <= '0;
					row_q <= r_last ? 10'd0 : rr + 10'd1;
				end else begin
					col_q <= k + COL_W'(1);
					row_q <= rr;
				end
			end
		end
	end

	// ---- line store: read at accept, write back in the following cycle ----
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1  <= line_mem[k];
			pix_s1 <= pixels;
			k_s1   <= k;
			pos_s1 <= pos_now;
		end
		if (s1_v_q) begin
			line_mem[k_s1] <= {rd_s1.prev_up1, pix_s1.prev_pixel,
				rd_s1.curr_up1, pix_s1.curr_pixel};
			pos_s2 <= pos_s1;
		end
	end

	// ---- 3x3 windows, index [frame][row][col], col 2 newest ----
	assign up2[0] = rd_s1.prev_up2;
	assign up2[1] = rd_s1.curr_up2;
	assign up1[0] = rd_s1.prev_up1;
	assign up1[1] = rd_s1.curr_up1;
	assign nw[0]  = pix_s1.prev_pixel;
	assign nw[1]  = pix_s1.curr_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < 2; f++)
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						win_q[f][r][c] <= 8'd0;
		end else if (s1_v_q) begin
			for (int f = 0; f < 2; f++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[f][r][0] <= win_q[f][r][1];
					win_q[f][r][1] <= win_q[f][r][2];
				end
				win_q[f][0][2] <= up2[f];
				win_q[f][1][2] <= up1[f];
				win_q[f][2][2] <= nw[f];
			end
		end
	end

	// ---- gradients of the window built by the item in s2 ----
	always_comb begin
		gx_a = grad_code(
			sum4(win_q[0][1][1], win_q[0][2][1], win_q[1][1][1], win_q[1][2][1]),
			sum4(win_q[0][1][0], win_q[0][2][0], win_q[1][1][0], win_q[1][2][0]));
		gx_b = grad_code(
			sum4(win_q[0][1][2], win_q[0][2][2], win_q[1][1][2], win_q[1][2][2]),
			sum4(win_q[0][1][1], win_q[0][2][1], win_q[1][1][1], win_q[1][2][1]));
		gy_a = grad_code(
			sum4(win_q[0][1][1], win_q[0][1][2], win_q[1][1][1], win_q[1][1][2]),
			sum4(win_q[0][0][1], win_q[0][0][2], win_q[1][0][1], win_q[1][0][2]));
		gy_c = grad_code(
			sum4(win_q[0][2][1], win_q[0][2][2], win_q[1][2][1], win_q[1][2][2]),
			sum4(win_q[0][1][1], win_q[0][1][2], win_q[1][1][1], win_q[1][1][2]));

		// X-shaped five point sums, centre plus diagonals
		x_prev = sum5(win_q[0][1][1], win_q[0][2][0], win_q[0][0][0],
			win_q[0][0][2], win_q[0][2][2]);
		x_curr = sum5(win_q[1][1][1], win_q[1][2][0], win_q[1][0][0],
			win_q[1][0][2], win_q[1][2][2]);
		t_num  = 12'(x_curr) - 12'(x_prev) + TEMP_OFFSET;
		t_prod = 25'(t_num) * 25'(DIV10_MUL);
		gt_a   = t_prod[23:16];
	end

	always_comb begin
		job.row   = pos_s2.row;
		job.col   = pos_s2.col;
		job.slots = {pos_s2.em_b && pos_s2.last_row, pos_s2.em_a && pos_s2.last_row,
			pos_s2.em_b, pos_s2.em_a};
		job.a_gx  = pos_s2.k_ge2 ? gx_a : FILL_CODE;
		job.a_gy  = pos_s2.r_ge2 ? gy_a : FILL_CODE;
		job.a_gt  = (pos_s2.k_ge2 && pos_s2.r_ge2) ? gt_a : FILL_CODE;
		job.b_gx  = gx_b;
		job.c_gy  = gy_c;
	end

	assign job_push = s2_v_q && (job.slots != 4'd0);

endmodule

### design/ofg_job_queue.sv
// ----------------------------------------------------------------------------
// ofg_job_queue: job FIFO between front and back
// Register-based, head presented combinationally, fill level exported.
// ----------------------------------------------------------------------------
module ofg_job_queue import ofg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  job_t                 job_in,
	input  logic                 pop,
	output job_t                 head,
	output logic [JOB_LVL_W-1:0] level
);

	job_t                 jobs_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [JOB_LVL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push)
			jobs_q[wr_ptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + JOB_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + JOB_PTR_W'(1);
			if (push && !pop)
				level_q <= level_q + JOB_LVL_W'(1);
			else if (pop && !push)
				level_q <= level_q - JOB_LVL_W'(1);
		end
	end

	assign head  = jobs_q[rd_ptr_q];
	assign level = level_q;

endmodule

### design/ofg_back.sv
// ----------------------------------------------------------------------------
// ofg_back: result sequencer and output register
// Walks the head job slots oldest first, one result per cycle while popped.
// ----------------------------------------------------------------------------
module ofg_back import ofg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    has_job,
	input  job_t    head,
	output logic    job_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic [3:0] done_q, rem, rest;
	slot_t      sel;
	logic       out_v_q, load, take, last;
	result_t    res, result_q;

	assign load = !out_v_q || pop;
	assign take = load && has_job;

	always_comb begin
		rem = head.slots & ~done_q;
		if (rem[0])
			sel = SLOT_A;
		else if (rem[1])
			sel = SLOT_B;
		else if (rem[2])
			sel = SLOT_C;
		else
			sel = SLOT_D;
		rest = rem & ~sel;
		last = (rest == 4'd0);

		res.last_of_run = last;
		case (sel)
			SLOT_A: begin
				res.out_row = head.row - 10'd1;
				res.out_col = head.col - 10'd1;
				res.grad_x  = head.a_gx;
				res.grad_y  = head.a_gy;
				res.grad_t  = head.a_gt;
			end
			SLOT_B: begin
				res.out_row = head.row - 10'd1;
				res.out_col = head.col;
				res.grad_x  = head.b_gx;
				res.grad_y  = FILL_CODE;
				res.grad_t  = FILL_CODE;
			end
			SLOT_C: begin
				res.out_row = head.row;
				res.out_col = head.col - 10'd1;
				res.grad_x  = FILL_CODE;
				res.grad_y  = head.c_gy;
				res.grad_t  = FILL_CODE;
			end
			default: begin
				res.out_row = head.row;
				res.out_col = head.col;
				res.grad_x  = FILL_CODE;
				res.grad_y  = FILL_CODE;
				res.grad_t  = FILL_CODE;
			end
		endcase
	end

	assign job_pop = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 4'd0;
			out_v_q <= 1'b0;
		end else begin
			if (load)
				out_v_q <= has_job;
			if (take)
				done_q <= last ? 4'd0 : (done_q | sel);
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			result_q <= res;
	end

	assign empty  = !out_v_q;
	assign result = result_q;

endmodule

### design/optical_flow_gradients_unit.sv
// ----------------------------------------------------------------------------
// optical_flow_gradients_unit: spatial and temporal gradient estimation
// Raster pixel pairs in, offset-coded x/y/t gradients per pixel out.
// ----------------------------------------------------------------------------
//
//  channel  | signals                            | transfer when
//  ---------+------------------------------------+----------------------
//  input    | push, full, pixels                 | push && !full
//  result   | pop, empty, result                 | pop && !empty
//  config   | cfg_we, cfg_index, cfg_data        | cfg_we
//
// One pixel pair per cycle sustained while full stays low. An input runs
// through two front stages (line store read, then window shift and
// gradient math) into an 8-entry job queue; the back end drains one result
// per cycle while results are popped, so an input causing n results (n is
// 0..4; up to 4 on the last pixel of a frame) holds the result side for all
// n of them. full rises once queued jobs plus the two front stages reach
// the queue depth; the last row (two results per pixel) therefore throttles
// input to half rate. Reset clears counters, windows and the queue; the
// line store needs no clearing pass.
//
module optical_flow_gradients_unit import ofg_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  pixel_pair_t pixels,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	logic                 job_push, job_pop, has_job;
	job_t                 job, head;
	logic [JOB_LVL_W-1:0] level;

	// front: position tracking, line store, windows, gradient codes
	ofg_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixels   (pixels),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.level    (level),
		.job_push (job_push),
		.job      (job)
	);

	// decoupling queue, one job per input that emits anything
	ofg_job_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.job_in(job),
		.pop   (job_pop),
		.head  (head),
		.level (level)
	);

	assign has_job = (level != '0);

	// back: expands each job into its results, registered output
	ofg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.has_job(has_job),
		.head   (head),
		.job_pop(job_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

`ifndef SYNTHESIS
	// the intake throttle must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> (level < JOB_LVL_W'(JOB_DEPTH)))
		else $error("job queue overflow");

	// a saturated queue must hold off new input
	a_full_when_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(level == JOB_LVL_W'(JOB_DEPTH)) |-> full)
		else $error("full low with queue saturated");

	// retiring a job always leaves its final result in the output register
	a_retire_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (!empty && result.last_of_run))
		else $error("retired job without final result");
`endif

endmodule
